FILE: rtl/core/id3fw_pkg.sv
// ----------------------------------------------------------------------------
// id3fw_pkg
// Types and constants of the tag frame walker.
// ----------------------------------------------------------------------------
package id3fw_pkg;

   localparam int SIZE_BITS_DEFAULT = 28;
   localparam int ACCUM_BITS        = 28;
   localparam int TAG_HDR_LEN       = 10;
   localparam int FRAME_HDR_LEN     = 10;
   localparam int ID_BYTES          = 4;
   localparam int SIZE_END          = 8;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic CSR_TARGET_ID = 1'b0;
   localparam logic CSR_LIST_MODE = 1'b1;

   typedef enum logic [1:0] {
      PH_TAG  = 2'd0,
      PH_HDR  = 2'd1,
      PH_PAY  = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_NOT_FOUND = 2'd1,
      KIND_END       = 2'd2,
      KIND_TRUNC     = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] frame_id;
      logic [7:0]  frame_index;
      logic [7:0]  value_byte;
      logic        last_of_frame;
   } rsp_type;

endpackage

FILE: rtl/core/id3v2_frame_walker.sv
// ----------------------------------------------------------------------------
// id3v2_frame_walker
// Walks the frames of a tagged audio stream one byte at a time and emits
// frame payload bytes (extract or list mode) and end-of-walk results.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   req_data (in_byte, stream_end)
//  rsp_      out        rsp_valid/rsp_stall   rsp_data (kind .. last_of_frame)
//  csr_      in         csr_we                csr_index, csr_wdata
//
//  One byte per cycle while req_stall is low. A byte is decoded in the
//  cycle it is taken and its zero, one or two results are registered in a
//  four-entry result queue. req_stall rises while fewer than two queue entries
//  are free. Synchronous reset clears the walk state, the registers and the
//  queue; stream_end returns the walk state to its reset values.
// ----------------------------------------------------------------------------
module id3v2_frame_walker
   import id3fw_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QCNT_BITS-1:0] QCNT_MAX_ACCEPT = QCNT_BITS'(QUEUE_DEPTH - 2);

   logic [31:0]           target_id_ff;
   logic                  list_mode_ff;

   phase_type             phase_ff, phase_in;
   logic [3:0]            header_count_ff, header_count_in;
   logic [31:0]           id_shift_ff, id_shift_in;
   logic [ACCUM_BITS-1:0] size_accum_ff, size_accum_in;
   logic [SIZE_BITS-1:0]  remaining_ff, remaining_in;
   logic                  matched_ff, matched_in;
   logic [7:0]            frame_count_ff, frame_count_in;

   rsp_type               q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   logic                  accept;
   logic                  pop;
   logic                  has_a, has_b;
   rsp_type               res_a, res_b;
   logic [SIZE_BITS-1:0]  size_sat;
   logic [1:0]            n_push;
   kind_type              end_kind;

   assign accept    = req_valid && !req_stall;
   assign req_stall = count_ff > QCNT_MAX_ACCEPT;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign end_kind  = list_mode_ff ? KIND_END : KIND_NOT_FOUND;

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      id_shift_in     = id_shift_ff;
      size_accum_in   = size_accum_ff;
      remaining_in    = remaining_ff;
      matched_in      = matched_ff;
      frame_count_in  = frame_count_ff;
      has_a           = 1'b0;
      has_b           = 1'b0;
      res_a           = '{KIND_PAYLOAD, 32'd0, 8'd0, 8'd0, 1'b0};
      res_b           = '{KIND_PAYLOAD, 32'd0, 8'd0, 8'd0, 1'b0};
      size_sat        = '0;

      unique case (phase_ff)
         PH_TAG: begin
            if (header_count_ff == 4'(TAG_HDR_LEN - 1)) begin
               header_count_in = '0;
               phase_in        = PH_HDR;
            end else begin
               header_count_in = header_count_ff + 4'd1;
            end
         end
         PH_HDR: begin
            if (header_count_ff == '0) begin
               id_shift_in   = '0;
               size_accum_in = '0;
            end
            if (header_count_ff < 4'(ID_BYTES)) begin
               id_shift_in = {id_shift_in[23:0], req_data.in_byte};
            end else if (header_count_ff < 4'(SIZE_END)) begin
               size_accum_in = {size_accum_in[ACCUM_BITS-8:0], req_data.in_byte[6:0]};
            end
            if ((size_accum_in >> SIZE_BITS) != '0) begin
               size_sat = '1;
            end else begin
               size_sat = size_accum_in[SIZE_BITS-1:0];
            end
            if (header_count_ff == 4'(FRAME_HDR_LEN - 1)) begin
               header_count_in = '0;
               if (size_sat == '0) begin
                  has_a    = 1'b1;
                  res_a    = '{end_kind, 32'd0, frame_count_ff, 8'd0, 1'b0};
                  phase_in = PH_DONE;
               end else begin
                  remaining_in = size_sat;
                  matched_in   = id_shift_in == target_id_ff;
                  phase_in     = PH_PAY;
               end
            end else begin
               header_count_in = header_count_ff + 4'd1;
            end
         end
         PH_PAY: begin
            remaining_in = remaining_ff - 1'b1;
            if (list_mode_ff || matched_ff) begin
               has_a = 1'b1;
               res_a = '{KIND_PAYLOAD, id_shift_ff, frame_count_ff, req_data.in_byte,
                         remaining_in == '0};
            end
            if (remaining_in == '0) begin
               if (!list_mode_ff && matched_ff) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in        = PH_HDR;
                  header_count_in = '0;
               end
               if (frame_count_ff != 8'hFF) begin
                  frame_count_in = frame_count_ff + 8'd1;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (req_data.stream_end) begin
         if (phase_in != PH_DONE) begin
            has_b = 1'b1;
            if (phase_in == PH_HDR && header_count_in == '0) begin
               res_b = '{end_kind, 32'd0, frame_count_in, 8'd0, 1'b0};
            end else begin
               res_b = '{KIND_TRUNC, 32'd0, frame_count_in, 8'd0, 1'b0};
            end
         end
         phase_in        = PH_TAG;
         header_count_in = '0;
         id_shift_in     = '0;
         size_accum_in   = '0;
         remaining_in    = '0;
         matched_in      = 1'b0;
         frame_count_in  = '0;
      end
   end

   always_comb begin
      n_push    = {1'b0, has_a} + {1'b0, has_b};
      if (!accept) begin
         n_push = '0;
      end
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(n_push);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
      count_in  = count_ff + QCNT_BITS'(n_push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_id_ff <= '0;
         list_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_ID: target_id_ff <= csr_wdata;
            CSR_LIST_MODE: list_mode_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TAG;
         header_count_ff <= '0;
         id_shift_ff     <= '0;
         size_accum_ff   <= '0;
         remaining_ff    <= '0;
         matched_ff      <= 1'b0;
         frame_count_ff  <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         id_shift_ff     <= id_shift_in;
         size_accum_ff   <= size_accum_in;
         remaining_ff    <= remaining_in;
         matched_ff      <= matched_in;
         frame_count_ff  <= frame_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (has_a) begin
            q_ff[wr_ptr_ff] <= res_a;
            if (has_b) begin
               q_ff[wr_ptr_ff + QPTR_BITS'(1)] <= res_b;
            end
         end else if (has_b) begin
            q_ff[wr_ptr_ff] <= res_b;
         end
      end
   end

endmodule
